// ===== rtl/ptl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptl_pkg;

    // Width of the reported line number and its saturation value.
    localparam int              LINE_OUT_W   = 20;
    localparam logic [19:0]     LINE_OUT_MAX = 20'hFFFFF;

    // Lexer modes.
    localparam logic [3:0] MODE_IDLE    = 4'd0;
    localparam logic [3:0] MODE_IDENT   = 4'd1;
    localparam logic [3:0] MODE_HEX     = 4'd2;
    localparam logic [3:0] MODE_DEC     = 4'd3;
    localparam logic [3:0] MODE_CODE    = 4'd4;
    localparam logic [3:0] MODE_LT      = 4'd5;
    localparam logic [3:0] MODE_GT      = 4'd6;
    localparam logic [3:0] MODE_COLON   = 4'd7;
    localparam logic [3:0] MODE_STRING  = 4'd8;
    localparam logic [3:0] MODE_COMMENT = 4'd9;
    localparam logic [3:0] MODE_ENDED   = 4'd10;
    localparam logic [3:0] MODE_HALTED  = 4'd11;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Token classes.
    localparam logic [2:0] CLS_IDENT  = 3'd0;
    localparam logic [2:0] CLS_HEX    = 3'd1;
    localparam logic [2:0] CLS_DEC    = 3'd2;
    localparam logic [2:0] CLS_CODE   = 3'd3;
    localparam logic [2:0] CLS_OP     = 3'd4;
    localparam logic [2:0] CLS_STRING = 3'd5;
    localparam logic [2:0] CLS_EOI    = 3'd6;

    // Error codes.
    localparam logic [1:0] ERR_UNKNOWN     = 2'd0;
    localparam logic [1:0] ERR_NO_QUOTE    = 2'd1;
    localparam logic [1:0] ERR_NO_COMMENT  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] cls;
        logic [7:0] ch;
        logic [1:0] err;
        logic       last;
    } result_t;

    // All results caused by one request, at most three.
    typedef struct packed {
        logic [1:0]    n;
        result_t [2:0] res;
    } bundle_t;

    typedef struct packed {
        bundle_t                 b;
        logic [LINE_OUT_W-1:0]   line;
    } slot_t;

endpackage

`default_nettype wire

// ===== rtl/ptl_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ptl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface ptl_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [2:0]  token_class;
    logic [7:0]  char_value;
    logic [1:0]  error_code;
    logic [19:0] line_number;
    logic        last_result;

    modport source (output valid, output result_kind, output token_class, output char_value,
                    output error_code, output line_number, output last_result, input ready);
    modport sink   (input valid, input result_kind, input token_class, input char_value,
                    input error_code, input line_number, input last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptl_lex_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One lexing step: from the current mode and one request, the results it
// causes and the mode that follows.
module ptl_lex_core import ptl_pkg::*;
(
    input  logic [3:0] mode,
    input  logic [7:0] char_in,
    input  logic       end_of_input,
    output bundle_t    bundle,
    output logic [3:0] mode_next,
    output logic       newline
);

    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
        logic [3:0] mode;
    } idle_t;

    function automatic result_t mk(input logic [1:0] kind, input logic [2:0] cls,
                                   input logic [7:0] ch, input logic [1:0] err);
        result_t r;
        r.kind = kind;
        r.cls  = cls;
        r.ch   = ch;
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return is_digit(c) || c == "." || c == "_";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic is_single_op(input logic [7:0] c);
        return c == "=" || c == ";" || c == "," || c == "[" || c == "]" || c == "(" ||
               c == ")" || c == "@" || c == "*" || c == "+" || c == "-" || c == "/" ||
               c == "^";
    endfunction

    function automatic logic [2:0] class_of(input logic [3:0] m);
        logic [2:0] c;
        case (m)
            MODE_IDENT: c = CLS_IDENT;
            MODE_HEX:   c = CLS_HEX;
            MODE_DEC:   c = CLS_DEC;
            MODE_CODE:  c = CLS_CODE;
            default:    c = CLS_OP;
        endcase
        return c;
    endfunction

    // Lexing of a character that starts after the gap between tokens.
    function automatic idle_t lex_idle(input logic [7:0] c);
        idle_t t;
        t.n    = 2'd0;
        t.r0   = '0;
        t.r1   = '0;
        t.mode = MODE_IDLE;
        if (c == " " || c == 8'h0A || c == 8'h0D) begin
            t.mode = MODE_IDLE;
        end else if (is_letter(c)) begin
            t.n = 2'd1; t.r0 = mk(KIND_CHAR, CLS_IDENT, lower(c), ERR_UNKNOWN);
            t.mode = MODE_IDENT;
        end else if (c == "$") begin
            t.n = 2'd1; t.r0 = mk(KIND_CHAR, CLS_HEX, c, ERR_UNKNOWN);
            t.mode = MODE_HEX;
        end else if (is_digit(c) || c == ".") begin
            t.n = 2'd1; t.r0 = mk(KIND_CHAR, CLS_DEC, c, ERR_UNKNOWN);
            t.mode = MODE_DEC;
        end else if (c == "#") begin
            t.n = 2'd1; t.r0 = mk(KIND_CHAR, CLS_CODE, c, ERR_UNKNOWN);
            t.mode = MODE_CODE;
        end else if (c == "<" || c == ">" || c == ":") begin
            t.n = 2'd1; t.r0 = mk(KIND_CHAR, CLS_OP, c, ERR_UNKNOWN);
            t.mode = (c == "<") ? MODE_LT : (c == ">") ? MODE_GT : MODE_COLON;
        end else if (is_single_op(c)) begin
            t.n = 2'd2;
            t.r0 = mk(KIND_CHAR, CLS_OP, c, ERR_UNKNOWN);
            t.r1 = mk(KIND_END, CLS_OP, 8'd0, ERR_UNKNOWN);
            t.mode = MODE_IDLE;
        end else if (c == 8'h27) begin
            t.n = 2'd1; t.r0 = mk(KIND_CHAR, CLS_STRING, c, ERR_UNKNOWN);
            t.mode = MODE_STRING;
        end else if (c == "{") begin
            t.mode = MODE_COMMENT;
        end else begin
            t.n = 2'd1; t.r0 = mk(KIND_ERROR, CLS_IDENT, c, ERR_UNKNOWN);
            t.mode = MODE_HALTED;
        end
        return t;
    endfunction

    idle_t      idl;
    logic       active;
    logic       more;
    logic       pair;
    logic [7:0] tok_ch;

    assign idl    = lex_idle(char_in);
    assign active = mode <= MODE_COMMENT;

    always_comb
    begin
        bundle    = '0;
        mode_next = mode;
        more      = 1'b0;
        pair      = 1'b0;
        tok_ch    = (mode == MODE_IDENT || mode == MODE_HEX) ? lower(char_in) : char_in;

        if (mode == MODE_ENDED) begin
            bundle.n      = 2'd1;
            bundle.res[0] = mk(KIND_END, CLS_EOI, 8'd0, ERR_UNKNOWN);
        end else if (!active) begin
            mode_next = MODE_HALTED;
        end else if (end_of_input) begin
            mode_next = MODE_ENDED;
            if (mode == MODE_STRING) begin
                bundle.n      = 2'd1;
                bundle.res[0] = mk(KIND_ERROR, CLS_IDENT, 8'd0, ERR_NO_QUOTE);
                mode_next     = MODE_HALTED;
            end else if (mode == MODE_COMMENT) begin
                bundle.n      = 2'd1;
                bundle.res[0] = mk(KIND_ERROR, CLS_IDENT, 8'd0, ERR_NO_COMMENT);
                mode_next     = MODE_HALTED;
            end else if (mode == MODE_IDLE) begin
                bundle.n      = 2'd1;
                bundle.res[0] = mk(KIND_END, CLS_EOI, 8'd0, ERR_UNKNOWN);
            end else begin
                bundle.n      = 2'd2;
                bundle.res[0] = mk(KIND_END, class_of(mode), 8'd0, ERR_UNKNOWN);
                bundle.res[1] = mk(KIND_END, CLS_EOI, 8'd0, ERR_UNKNOWN);
            end
        end else begin
            case (mode)
                MODE_IDLE:
                begin
                    bundle.n      = idl.n;
                    bundle.res[0] = idl.r0;
                    bundle.res[1] = idl.r1;
                    mode_next     = idl.mode;
                end
                MODE_STRING:
                begin
                    bundle.n      = 2'd1;
                    bundle.res[0] = mk(KIND_CHAR, CLS_STRING, char_in, ERR_UNKNOWN);
                    if (char_in == 8'h27) begin
                        bundle.n      = 2'd2;
                        bundle.res[1] = mk(KIND_END, CLS_STRING, 8'd0, ERR_UNKNOWN);
                        mode_next     = MODE_IDLE;
                    end
                end
                MODE_COMMENT:
                begin
                    if (char_in == "}") begin
                        mode_next = MODE_IDLE;
                    end
                end
                default:
                begin
                    // A token is in progress: extend it, close an operator pair,
                    // or end it and lex the character afresh.
                    case (mode)
                        MODE_IDENT: more = is_letter(char_in);
                        MODE_HEX:   more = is_hex(char_in);
                        MODE_DEC:   more = is_num(char_in);
                        MODE_CODE:  more = is_num(char_in);
                        MODE_LT:    pair = char_in == "=" || char_in == "<" || char_in == ">";
                        MODE_GT:    pair = char_in == "=" || char_in == "<" || char_in == ">";
                        default:    pair = char_in == "=";
                    endcase
                    if (more) begin
                        bundle.n      = 2'd1;
                        bundle.res[0] = mk(KIND_CHAR, class_of(mode), tok_ch, ERR_UNKNOWN);
                    end else if (pair) begin
                        bundle.n      = 2'd2;
                        bundle.res[0] = mk(KIND_CHAR, CLS_OP, char_in, ERR_UNKNOWN);
                        bundle.res[1] = mk(KIND_END, CLS_OP, 8'd0, ERR_UNKNOWN);
                        mode_next     = MODE_IDLE;
                    end else begin
                        bundle.n      = idl.n + 2'd1;
                        bundle.res[0] = mk(KIND_END, class_of(mode), 8'd0, ERR_UNKNOWN);
                        bundle.res[1] = idl.r0;
                        bundle.res[2] = idl.r1;
                        mode_next     = idl.mode;
                    end
                end
            endcase
        end

        for (int i = 0; i < 3; i++) begin
            bundle.res[i].last = (2'(i) == bundle.n - 2'd1);
        end
    end

    // A newline taken in by the lexer bumps the line count after this step.
    assign newline = active && !end_of_input && char_in == 8'h0A &&
                     mode_next != MODE_HALTED;

endmodule

`default_nettype wire

// ===== rtl/pascal_token_lexer.sv =====
// The results of a taken request are registered in the queue and reach result_ch from its head slot.
// Throughput: one request per cycle while the queue has a free slot; a request's results leave in turn.
// Up to two requests' results are queued; char_ch.ready drops only while both slots are full.
// Reset (rst_n, asynchronous, active low): lexer between tokens, line count 1, queue empty.
`timescale 1ns / 1ps
`default_nettype none

module pascal_token_lexer import ptl_pkg::*;
#(
    parameter int LINE_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [LINE_OUT_W-1:0] cfg_wdata,
    ptl_char_if.sink              char_ch,
    ptl_result_if.source          result_ch
);

    // The lexer state is a mode register plus the line counter. Each request
    // is lexed combinationally by ptl_lex_core, which returns up to three results
    // as a bundle. Bundles wait in a two-slot queue; the head slot is the
    // output register, and a small index walks through its results one per
    // cycle while result_ch.ready is high. Because mode and line count advance
    // when a request is taken, the lexer runs ahead of the output and never
    // waits on it unless the queue is full.

    logic [3:0]           mode_reg;
    logic [3:0]           mode_next;
    bundle_t              bundle;
    logic                 newline;

    logic [LINE_BITS-1:0] line_count_reg;
    logic [31:0]          line_wide;
    logic [LINE_OUT_W-1:0] line_sat;

    slot_t                slot0_reg;
    slot_t                slot1_reg;
    slot_t                new_slot;
    logic [1:0]           count_reg;
    logic [1:0]           idx_reg;

    logic                 accept;
    logic                 push;
    logic                 out_fire;
    logic                 pop;
    result_t              cur;

    ptl_lex_core u_core
    (
        .mode         (mode_reg),
        .char_in      (char_ch.char_in),
        .end_of_input (char_ch.end_of_input),
        .bundle       (bundle),
        .mode_next    (mode_next),
        .newline      (newline)
    );

    // The reported line number saturates at the width of the output field.
    assign line_wide = 32'(line_count_reg);
    assign line_sat  = (line_wide > 32'(LINE_OUT_MAX)) ? LINE_OUT_MAX
                                                       : line_wide[LINE_OUT_W-1:0];

    assign char_ch.ready = count_reg < 2'd2;
    assign accept        = char_ch.valid && char_ch.ready;
    // Requests that cause no result (spaces, comments, halted lexer) only
    // move the state and never take a queue slot.
    assign push          = accept && bundle.n != 2'd0;

    assign new_slot.b    = bundle;
    assign new_slot.line = line_sat;

    assign cur                   = slot0_reg.b.res[idx_reg];
    assign result_ch.valid       = count_reg != 2'd0;
    assign result_ch.result_kind = cur.kind;
    assign result_ch.token_class = cur.cls;
    assign result_ch.char_value  = cur.ch;
    assign result_ch.error_code  = cur.err;
    assign result_ch.line_number = slot0_reg.line;
    assign result_ch.last_result = cur.last;

    assign out_fire = result_ch.valid && result_ch.ready;
    assign pop      = out_fire && idx_reg == slot0_reg.b.n - 2'd1;

    // Lexer state. A configuration write loads the line counter directly;
    // the user must issue it only while the block is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_IDLE;
            line_count_reg <= LINE_BITS'(1);
        end else begin
            if (accept) begin
                mode_reg <= mode_next;
            end
            if (cfg_we) begin
                line_count_reg <= LINE_BITS'(cfg_wdata);
            end else if (accept && newline && line_count_reg != '1) begin
                line_count_reg <= line_count_reg + LINE_BITS'(1);
            end
        end
    end

    // Queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end else begin
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
            if (pop) begin
                idx_reg <= 2'd0;
            end else if (out_fire) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Queue payload.
    always_ff @(posedge clk)
    begin
        if (push && (count_reg == 2'd0 || (count_reg == 2'd1 && pop))) begin
            slot0_reg <= new_slot;
        end else if (pop && count_reg == 2'd2) begin
            slot0_reg <= slot1_reg;
        end
        if (push && count_reg == 2'd1 && !pop) begin
            slot1_reg <= new_slot;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ptl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ptl_checker import ptl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [2:0]  out_class,
    input logic [19:0] out_line,
    input logic        out_last
);

    logic        out_fire;
    logic        halted_reg;
    logic        have_prev_reg;
    logic [19:0] prev_line_reg;

    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            halted_reg    <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_line_reg <= 20'd0;
        end else begin
            if (out_fire && out_kind == KIND_ERROR) begin
                halted_reg <= 1'b1;
            end
            if (cfg_we) begin
                have_prev_reg <= 1'b0;
            end else if (out_fire) begin
                have_prev_reg <= 1'b1;
                prev_line_reg <= out_line;
            end
        end
    end

    // An error ends its request and carries no class.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_ERROR |-> out_last && out_class == CLS_IDENT)
        else $error("error result is not the last one or has a class");

    // Once an error has been delivered the lexer stays silent until reset.
    a_silent_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !out_valid)
        else $error("result after an error");

    // Line numbers never go back between configuration writes.
    a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && have_prev_reg && !cfg_we |-> out_line >= prev_line_reg)
        else $error("line number decreased");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before it was taken");

endmodule

bind pascal_token_lexer ptl_checker u_ptl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_kind  (result_ch.result_kind),
    .out_class (result_ch.token_class),
    .out_line  (result_ch.line_number),
    .out_last  (result_ch.last_result)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ptl_pkg::*;

    // Fields that are zero in results where they carry no meaning.
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [2:0] CLS_NONE = 3'd0;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Cycles without any handshake on either channel before the run is declared hung.
    localparam int QUIET_LIMIT = 4000;

    // One result as it appears on result_ch, line number included.
    typedef struct packed {
        logic [1:0]            kind;
        logic [2:0]            cls;
        logic [7:0]            ch;
        logic [1:0]            err;
        logic [LINE_OUT_W-1:0] line;
        logic                  last;
    } lex_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [LINE_OUT_W-1:0] cfg_wdata;

    ptl_char_if   char_ch ();
    ptl_result_if result_ch ();

    pascal_token_lexer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .char_ch   (char_ch),
        .result_ch (result_ch)
    );

    // Character classes of the lexer. These are shared by the predictor and by the
    // stimulus generator, which must know which bytes cannot start a token.
    function automatic bit is_blank(logic [7:0] c);
        return c == " " || c == CH_LF || c == CH_CR;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return is_digit(c) || c == "." || c == "_";
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_single_op(logic [7:0] c);
        case (c)
            "=", ";", ",", "[", "]", "(", ")", "@", "*", "+", "-", "/", "^": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit starts_lexeme(logic [7:0] c);
        return is_blank(c) || is_letter(c) || is_digit(c) || c == "." || c == "$" ||
               c == "#" || c == "<" || c == ">" || c == ":" || is_single_op(c) ||
               c == "'" || c == "{";
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // The scoreboard carries its own copy of the lexer: mode, line count and the
    // queue of results that the accepted requests should have produced.
    class token_checker;
        lex_result_t           expected_tokens[$];
        logic [3:0]            mode;
        logic [LINE_OUT_W-1:0] line_cnt;
        int                    mismatch_count;

        function new();
            mode           = MODE_IDLE;
            line_cnt       = 20'd1;
            mismatch_count = 0;
        endfunction

        function void load_start_line(logic [LINE_OUT_W-1:0] value);
            line_cnt = value;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void add_result(logic [1:0] kind, logic [2:0] cls, logic [7:0] ch,
                                 logic [1:0] err);
            lex_result_t r;
            r.kind = kind;
            r.cls  = cls;
            r.ch   = ch;
            r.err  = err;
            r.line = line_cnt;
            r.last = 1'b0;
            expected_tokens = {expected_tokens, r};
        endfunction

        function logic [2:0] class_of_mode(logic [3:0] m);
            case (m)
                MODE_IDENT: return CLS_IDENT;
                MODE_HEX:   return CLS_HEX;
                MODE_DEC:   return CLS_DEC;
                MODE_CODE:  return CLS_CODE;
                default:    return CLS_OP;
            endcase
        endfunction

        // A byte seen between tokens.
        function void lex_gap_char(logic [7:0] c);
            if (is_blank(c)) begin
                mode = MODE_IDLE;
            end
            else if (is_letter(c)) begin
                add_result(KIND_CHAR, CLS_IDENT, to_lower(c), ERR_NONE);
                mode = MODE_IDENT;
            end
            else if (c == "$") begin
                add_result(KIND_CHAR, CLS_HEX, c, ERR_NONE);
                mode = MODE_HEX;
            end
            else if (is_digit(c) || c == ".") begin
                add_result(KIND_CHAR, CLS_DEC, c, ERR_NONE);
                mode = MODE_DEC;
            end
            else if (c == "#") begin
                add_result(KIND_CHAR, CLS_CODE, c, ERR_NONE);
                mode = MODE_CODE;
            end
            else if (c == "<" || c == ">" || c == ":") begin
                add_result(KIND_CHAR, CLS_OP, c, ERR_NONE);
                mode = (c == "<") ? MODE_LT : (c == ">") ? MODE_GT : MODE_COLON;
            end
            else if (is_single_op(c)) begin
                add_result(KIND_CHAR, CLS_OP, c, ERR_NONE);
                add_result(KIND_END, CLS_OP, 8'h00, ERR_NONE);
                mode = MODE_IDLE;
            end
            else if (c == "'") begin
                add_result(KIND_CHAR, CLS_STRING, c, ERR_NONE);
                mode = MODE_STRING;
            end
            else if (c == "{") begin
                mode = MODE_COMMENT;
            end
            else begin
                add_result(KIND_ERROR, CLS_NONE, c, ERR_UNKNOWN);
                mode = MODE_HALTED;
            end
        endfunction

        function void lex_byte(logic [7:0] c);
            bit more;
            bit pair;
            more = 1'b0;
            pair = 1'b0;
            case (mode)
                MODE_IDLE: begin
                    lex_gap_char(c);
                    return;
                end
                MODE_STRING: begin
                    add_result(KIND_CHAR, CLS_STRING, c, ERR_NONE);
                    if (c == "'") begin
                        add_result(KIND_END, CLS_STRING, 8'h00, ERR_NONE);
                        mode = MODE_IDLE;
                    end
                    return;
                end
                MODE_COMMENT: begin
                    if (c == "}")
                        mode = MODE_IDLE;
                    return;
                end
                MODE_IDENT:           more = is_letter(c);
                MODE_HEX:             more = is_hex(c);
                MODE_DEC, MODE_CODE:  more = is_num(c);
                MODE_LT, MODE_GT:     pair = (c == "=" || c == "<" || c == ">");
                default:              pair = (c == "=");
            endcase

            if (more) begin
                add_result(KIND_CHAR, class_of_mode(mode),
                           (mode == MODE_IDENT || mode == MODE_HEX) ? to_lower(c) : c,
                           ERR_NONE);
            end
            else if (pair) begin
                add_result(KIND_CHAR, CLS_OP, c, ERR_NONE);
                add_result(KIND_END, CLS_OP, 8'h00, ERR_NONE);
                mode = MODE_IDLE;
            end
            else begin
                // The byte closes the token and is then lexed as what comes next.
                add_result(KIND_END, class_of_mode(mode), 8'h00, ERR_NONE);
                mode = MODE_IDLE;
                lex_gap_char(c);
            end
        endfunction

        function void lex_end_of_input();
            if (mode == MODE_STRING) begin
                add_result(KIND_ERROR, CLS_NONE, 8'h00, ERR_NO_QUOTE);
                mode = MODE_HALTED;
            end
            else if (mode == MODE_COMMENT) begin
                add_result(KIND_ERROR, CLS_NONE, 8'h00, ERR_NO_COMMENT);
                mode = MODE_HALTED;
            end
            else begin
                if (mode >= MODE_IDENT && mode <= MODE_COLON)
                    add_result(KIND_END, class_of_mode(mode), 8'h00, ERR_NONE);
                add_result(KIND_END, CLS_EOI, 8'h00, ERR_NONE);
                mode = MODE_ENDED;
            end
        endfunction

        function void note_request(logic [7:0] c, logic eoi);
            int n_before;
            n_before = expected_tokens.size();
            if (mode == MODE_HALTED)
                return;
            if (mode == MODE_ENDED) begin
                add_result(KIND_END, CLS_EOI, 8'h00, ERR_NONE);
            end
            else if (eoi) begin
                lex_end_of_input();
            end
            else begin
                lex_byte(c);
                // The newline counts after the results of its own request.
                if (c == CH_LF && mode != MODE_HALTED && line_cnt != LINE_OUT_MAX)
                    line_cnt = line_cnt + 1'b1;
            end
            if (expected_tokens.size() > n_before)
                expected_tokens[expected_tokens.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            mismatch_count++;
            if (mismatch_count <= 200)
                $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_result(lex_result_t got);
            lex_result_t want;
            if (expected_tokens.size() == 0) begin
                report($sformatf("result with none pending: kind %0d class %0d char %02h",
                                 got.kind, got.cls, got.ch));
                return;
            end
            want = expected_tokens.pop_front();
            if (got !== want)
                report($sformatf({"kind %0d/%0d class %0d/%0d char %02h/%02h err %0d/%0d ",
                                  "line %0d/%0d last %0d/%0d (got/expected)"},
                                 got.kind, want.kind, got.cls, want.cls, got.ch, want.ch,
                                 got.err, want.err, got.line, want.line,
                                 got.last, want.last));
        endtask
    endclass

    token_checker sb;

    // When set, the corresponding side runs without gaps until it flips back.
    bit src_steady;
    bit sink_steady;

    // Bytes of the token being composed, waiting to be sent.
    logic [7:0] token_text[$];
    string single_ops = "=;,[]()@*+-/^";

    // Adds one byte at the tail of the text waiting to be sent.
    function automatic void queue_byte(logic [7:0] b);
        token_text = {token_text, b};
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sends one request. Inputs change on the falling edge; the handshake is seen on
    // the rising edge. Valid stays high between back-to-back requests, so it is only
    // lowered when a gap is drawn.
    task send_request(logic [7:0] c, logic eoi);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 39) == 0)
            src_steady = !src_steady;
        @(negedge clk);
        if (gap > 0) begin
            char_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_ch.valid        = 1'b1;
        char_ch.char_in      = c;
        char_ch.end_of_input = eoi;
        do
            @(posedge clk);
        while (!char_ch.ready);
        sb.note_request(c, eoi);
    endtask

    // Holds the sender until every pending result has come out. Requests that make no
    // result (blanks, comment bytes) take no queue slot and are done once taken.
    task wait_idle();
        @(negedge clk);
        char_ch.valid = 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The write also reloads the line count, so the model follows at the same edge.
    task write_start_line(logic [LINE_OUT_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(posedge clk);
        sb.load_start_line(value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r == 52)
            return "_";
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] pick_num();
        int r;
        r = $urandom_range(0, 11);
        return (r < 10) ? 8'("0" + r) : (r == 10) ? 8'(".") : 8'("_");
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 2))
            0:       return " ";
            1:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Any byte but the one that would close the string or comment; half of them are
    // printable, the rest cover the whole byte range including the top bit.
    function automatic logic [7:0] pick_body_byte(logic [7:0] closer);
        logic [7:0] b;
        do
            b = $urandom_range(0, 1) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
        while (b == closer);
        return b;
    endfunction

    // Appends one well-formed lexeme, sometimes followed by a blank. Tokens that run
    // into each other are left to the predictor, which is how the token-closing path
    // gets exercised.
    task append_token();
        int len;
        int r;
        logic [7:0] b;
        len = $urandom_range(0, 5);
        case ($urandom_range(0, 9))
            0, 1: begin
                queue_byte(pick_letter());
                repeat (len) queue_byte(pick_letter());
            end
            2: begin
                queue_byte("$");
                repeat (len) begin
                    r = $urandom_range(0, 23);
                    if (r < 12)
                        b = pick_num();
                    else if (r < 18)
                        b = 8'("a" + r - 12);
                    else
                        b = 8'("A" + r - 18);
                    queue_byte(b);
                end
            end
            3: begin
                queue_byte($urandom_range(0, 3) == 0 ? 8'(".") :
                           8'("0" + $urandom_range(0, 9)));
                repeat (len) queue_byte(pick_num());
            end
            4: begin
                queue_byte("#");
                repeat (len) queue_byte(pick_num());
            end
            5: begin
                r = $urandom_range(0, 15);
                if (r < 13) begin
                    queue_byte(single_ops[r]);
                end
                else begin
                    queue_byte(r == 13 ? 8'("<") : r == 14 ? 8'(">") : 8'(":"));
                    r = $urandom_range(0, 3);
                    if (r < 3)
                        queue_byte(r == 0 ? 8'("=") : r == 1 ? 8'("<") : 8'(">"));
                end
            end
            6: begin
                queue_byte("'");
                repeat (len) queue_byte(pick_body_byte("'"));
                queue_byte("'");
            end
            7: begin
                queue_byte("{");
                if ($urandom_range(0, 2) == 0)
                    queue_byte("$");
                repeat (len) queue_byte(pick_body_byte("}"));
                queue_byte("}");
            end
            default: queue_byte(pick_blank());
        endcase
        if ($urandom_range(0, 1))
            queue_byte(pick_blank());
    endtask

    task random_tokens(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            append_token();
            while (token_text.size() > 0) begin
                send_request(token_text.pop_front(), 1'b0);
                sent++;
            end
            // Now and then the sender holds off until the output side has drained.
            if ($urandom_range(0, 29) == 0)
                wait_idle();
        end
    endtask

    // The receiver draws a stall for every result, with runs of no stalls in between.
    initial begin : result_sink
        int stall;
        lex_result_t got;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 39) == 0)
                sink_steady = !sink_steady;
            if (stall > 0) begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            got.kind = result_ch.result_kind;
            got.cls  = result_ch.token_class;
            got.ch   = result_ch.char_value;
            got.err  = result_ch.error_code;
            got.line = result_ch.line_number;
            got.last = result_ch.last_result;
            sb.check_result(got);
            @(negedge clk);
        end
    end

    // A hung handshake on either side ends the run.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((char_ch.valid && char_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        // Short directed stream: identifier closed by a hex numeral, hex closed by a
        // character code, code closed by "<>", then ">=", a colon closed by a blank,
        // a string holding 0xFF, NUL and a newline, and a comment holding a CR.
        logic [7:0] directed_text [0:24] = '{
            "A", "z", "_", "$", "f", "F", ".", "#", "0", "9",
            "<", ">", ">", "=", ":", " ",
            "'", 8'hFF, 8'h00, CH_LF, "'",
            "{", CH_CR, "}", CH_LF};
        int terminal_case;
        logic [7:0] b;

        sb = new();
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        char_ch.valid        = 1'b0;
        char_ch.char_in      = 8'h00;
        char_ch.end_of_input = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset line count of one is used as is for the directed part.
        foreach (directed_text[i])
            send_request(directed_text[i], 1'b0);

        // Line count from zero, just below saturation, at saturation, and anywhere.
        wait_idle();
        write_start_line('0);
        random_tokens(80);
        wait_idle();
        write_start_line(LINE_OUT_MAX - 1'b1);
        random_tokens(50);
        wait_idle();
        write_start_line(LINE_OUT_MAX);
        random_tokens(40);
        wait_idle();
        write_start_line(LINE_OUT_W'($urandom_range(0, 32'hFFFFF)));
        random_tokens(100);

        // The block cannot leave the ended or halted state without a reset, so each run
        // closes on one of four endings, picked at random.
        terminal_case = $urandom_range(0, 3);
        case (terminal_case)
            0: begin
                // End of input right after a token, possibly still open.
                append_token();
                if ($urandom_range(0, 1))
                    queue_byte(pick_letter());
                while (token_text.size() > 0)
                    send_request(token_text.pop_front(), 1'b0);
                send_request(8'($urandom_range(0, 255)), 1'b1);
            end
            1: begin
                // A byte that cannot start a token, more than half of them with the top bit set.
                do
                    b = $urandom_range(0, 1) ? 8'($urandom_range(128, 255)) :
                                               8'($urandom_range(0, 127));
                while (starts_lexeme(b));
                send_request(b, 1'b0);
            end
            2: begin
                // End of input inside a string.
                send_request("'", 1'b0);
                repeat ($urandom_range(0, 4)) send_request(pick_body_byte("'"), 1'b0);
                send_request(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                // End of input inside a comment.
                send_request("{", 1'b0);
                repeat ($urandom_range(0, 4)) send_request(pick_body_byte("}"), 1'b0);
                send_request(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase

        // Once ended, each request gives one end-of-input token; once halted, none.
        repeat ($urandom_range(3, 8))
            send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_request(8'($urandom_range(0, 255)), 1'b1);

        @(negedge clk);
        char_ch.valid = 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        // Anything the block still puts out now has no expectation and is caught.
        repeat (20) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
